// ===== sv/jfe_pkg.sv =====
// Shared types and constants for the JPEG frame extractor.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package jfe_pkg;

    localparam int COUNT_BITS_DEFAULT  = 24;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int CHUNK_BITS   = 24;
    localparam int MOVIE_BITS   = 32;
    localparam int CAPTURE_BITS = 16;

    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] MARKER_SOI    = 8'hD8;
    localparam logic [7:0] MARKER_EOI    = 8'hD9;

    localparam logic [CHUNK_BITS-1:0] CHUNK_MAX = {CHUNK_BITS{1'b1}};

    // What the back part must emit for one queued item.
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,  // no data byte, summary only
        MODE_DATA  = 2'd1,  // one byte passed through
        MODE_START = 2'd2   // start marker: FF then D8
    } mode_t;

    typedef struct packed {
        logic [7:0] fifo_byte;
        mode_t      mode;
        logic       last;
    } entry_t;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    // Tag AVI1; the index is the kept count minus two, modulo four.
    function automatic logic [7:0] avi_tag_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h41;
            2'd1:    b = 8'h56;
            2'd2:    b = 8'h49;
            default: b = 8'h31;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/jpeg_frame_extractor.sv =====
// JPEG frame extractor: one FIFO byte in per cycle unless stalled, kept bytes and summaries out.
// Throughput: one byte accepted per cycle unless the queue is full (in_stall).
// The back part emits one item per cycle while the output is not stalled, so a start
// marker (two bytes) or a capture end (summary) adds an item there.
// Reset (rst_n, asynchronous): counters, frame state and queue clear, tagging enabled.
`default_nettype none

module jpeg_frame_extractor #(
    parameter int COUNT_BITS  = jfe_pkg::COUNT_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = jfe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write_en,
    input  wire logic                               cfg_write_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         fifo_byte,
    input  wire logic                               capture_end,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    item_kind,
    output logic [7:0]                              data_byte,
    output logic [jfe_pkg::CHUNK_BITS-1:0]          chunk_bytes,
    output logic                                    pad_bytes,
    output logic [jfe_pkg::MOVIE_BITS-1:0]          movie_bytes,
    output logic [jfe_pkg::CAPTURE_BITS-1:0]        capture_count,
    output logic                                    last_result
);
    import jfe_pkg::*;

    // The tag enable is the only configuration register; it resets to enabled.
    logic   avi_tag_enable_reg;
    logic   push, pop, queue_full, queue_not_empty;
    entry_t push_entry, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avi_tag_enable_reg <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            avi_tag_enable_reg <= cfg_write_data;
        end
    end

    // The front part follows the marker bytes and frame state. Bytes that
    // produce nothing are dropped here and never reach the queue.
    jfe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .fifo_byte   (fifo_byte),
        .capture_end (capture_end),
        .queue_full  (queue_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    // The queue lets the front keep taking bytes while the back part spends
    // extra cycles on start markers and summaries or waits on a stalled output.
    jfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (queue_not_empty),
        .full       (queue_full)
    );

    // The back part owns the counters, applies the AVI1 tag and holds the
    // output register, emitting one item per cycle while the output is not stalled.
    jfe_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .avi_tag_enable (avi_tag_enable_reg),
        .head           (head),
        .head_valid     (queue_not_empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .item_kind      (item_kind),
        .data_byte      (data_byte),
        .chunk_bytes    (chunk_bytes),
        .pad_bytes      (pad_bytes),
        .movie_bytes    (movie_bytes),
        .capture_count  (capture_count),
        .last_result    (last_result)
    );

endmodule

`default_nettype wire

// ===== sv/jfe_front.sv =====
// Front part: accepts FIFO bytes, tracks markers and frame state, and
// queues the work for each byte that produces results. Uses jfe_pkg.
`default_nettype none

module jfe_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [7:0]      fifo_byte,
    input  wire logic            capture_end,
    input  wire logic            queue_full,
    output logic                 push,
    output jfe_pkg::entry_t      push_entry
);
    import jfe_pkg::*;

    logic [7:0] prev_reg, prev_next;
    logic       inside_reg, inside_next;
    logic       accept;
    mode_t      mode;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        mode        = MODE_NONE;
        inside_next = inside_reg;
        if (inside_reg)
        begin
            mode = MODE_DATA;
            if (prev_reg == MARKER_PREFIX && fifo_byte == MARKER_EOI)
            begin
                inside_next = 1'b0;
            end
        end
        else if (prev_reg == MARKER_PREFIX && fifo_byte == MARKER_SOI)
        begin
            mode        = MODE_START;
            inside_next = 1'b1;
        end
        prev_next = capture_end ? 8'h00 : fifo_byte;
    end

    assign push                 = accept && (mode != MODE_NONE || capture_end);
    assign push_entry.fifo_byte = fifo_byte;
    assign push_entry.mode      = mode;
    assign push_entry.last      = capture_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 8'h00;
            inside_reg <= 1'b0;
        end
        else if (accept)
        begin
            prev_reg   <= prev_next;
            inside_reg <= inside_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/jfe_queue.sv =====
// Short queue of work entries between the front and back parts.
// Uses jfe_pkg for the entry type.
`default_nettype none

module jfe_queue #(
    parameter int DEPTH = jfe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire jfe_pkg::entry_t push_entry,
    input  wire logic            pop,
    output jfe_pkg::entry_t      head,
    output logic                 not_empty,
    output logic                 full
);
    import jfe_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

    entry_t              slots_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full      = (cnt_reg == CNT_BITS'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slots_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== sv/jfe_back.sv =====
// Back part: expands queued entries into data and summary items, keeps the
// byte and capture counters and holds the output register. Uses jfe_pkg.
`default_nettype none

module jfe_back #(
    parameter int COUNT_BITS = jfe_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               avi_tag_enable,
    input  wire jfe_pkg::entry_t                    head,
    input  wire logic                               head_valid,
    output logic                                    pop,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    item_kind,
    output logic [7:0]                              data_byte,
    output logic [jfe_pkg::CHUNK_BITS-1:0]          chunk_bytes,
    output logic                                    pad_bytes,
    output logic [jfe_pkg::MOVIE_BITS-1:0]          movie_bytes,
    output logic [jfe_pkg::CAPTURE_BITS-1:0]        capture_count,
    output logic                                    last_result
);
    import jfe_pkg::*;

    logic [COUNT_BITS-1:0]   kept_reg, kept_next;
    logic [MOVIE_BITS-1:0]   movie_reg, movie_next;
    logic [CAPTURE_BITS-1:0] caps_reg, caps_next;
    logic [1:0]              phase_reg, phase_next;
    logic                    valid_reg, valid_next;

    kind_t                   kind_reg, kind_next;
    logic [7:0]              byte_reg, byte_next;
    logic [CHUNK_BITS-1:0]   chunk_reg, chunk_next;
    logic                    pad_reg, pad_next;
    logic [MOVIE_BITS-1:0]   omovie_reg, omovie_next;
    logic [CAPTURE_BITS-1:0] ocaps_reg, ocaps_next;
    logic                    olast_reg, olast_next;

    logic [1:0]              n_data;
    logic                    load, is_summary, final_result, tag_hit;
    logic [7:0]              raw_byte;
    logic [MOVIE_BITS-1:0]   kept_ext;

    assign load     = head_valid && (!valid_reg || !out_stall);
    assign kept_ext = MOVIE_BITS'(kept_reg);
    assign tag_hit  = avi_tag_enable && kept_reg >= COUNT_BITS'(2)
                      && kept_reg <= COUNT_BITS'(5);

    always_comb
    begin
        case (head.mode)
            MODE_DATA:  n_data = 2'd1;
            MODE_START: n_data = 2'd2;
            default:    n_data = 2'd0;
        endcase
        case (head.mode)
            MODE_START: raw_byte = phase_reg[0] ? MARKER_SOI : MARKER_PREFIX;
            default:    raw_byte = head.fifo_byte;
        endcase
        is_summary   = (phase_reg == n_data);
        final_result = is_summary || (phase_reg == n_data - 2'd1 && !head.last);
    end

    always_comb
    begin
        kept_next   = kept_reg;
        movie_next  = movie_reg;
        caps_next   = caps_reg;
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        byte_next   = byte_reg;
        chunk_next  = chunk_reg;
        pad_next    = pad_reg;
        omovie_next = omovie_reg;
        ocaps_next  = ocaps_reg;
        olast_next  = olast_reg;
        valid_next  = valid_reg && out_stall;
        if (load)
        begin
            valid_next = 1'b1;
            olast_next = final_result;
            phase_next = final_result ? 2'd0 : phase_reg + 2'd1;
            if (is_summary)
            begin
                movie_next  = movie_reg + kept_ext;
                caps_next   = caps_reg + 1'b1;
                kept_next   = '0;
                kind_next   = KIND_SUMMARY;
                byte_next   = 8'h00;
                chunk_next  = (kept_ext > MOVIE_BITS'(CHUNK_MAX)) ? CHUNK_MAX
                                                                  : kept_ext[CHUNK_BITS-1:0];
                pad_next    = kept_reg[0];
                omovie_next = movie_reg + kept_ext;
                ocaps_next  = caps_reg + 1'b1;
            end
            else
            begin
                if (kept_reg != '1)
                begin
                    kept_next = kept_reg + 1'b1;
                end
                kind_next   = KIND_DATA;
                byte_next   = tag_hit ? avi_tag_byte(kept_reg[1:0] ^ 2'b10) : raw_byte;
                chunk_next  = '0;
                pad_next    = 1'b0;
                omovie_next = '0;
                ocaps_next  = '0;
            end
        end
    end

    assign pop = load && final_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg  <= '0;
            movie_reg <= '0;
            caps_reg  <= '0;
            phase_reg <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            kept_reg  <= kept_next;
            movie_reg <= movie_next;
            caps_reg  <= caps_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        chunk_reg  <= chunk_next;
        pad_reg    <= pad_next;
        omovie_reg <= omovie_next;
        ocaps_reg  <= ocaps_next;
        olast_reg  <= olast_next;
    end

    assign out_valid     = valid_reg;
    assign item_kind     = kind_reg;
    assign data_byte     = byte_reg;
    assign chunk_bytes   = chunk_reg;
    assign pad_bytes     = pad_reg;
    assign movie_bytes   = omovie_reg;
    assign capture_count = ocaps_reg;
    assign last_result   = olast_reg;

endmodule

`default_nettype wire
